// ===== rtl/max_gap_seat_allocator_top_defines.svh =====
// Assertion macros for the seat allocator RTL.
`ifndef MAX_GAP_SEAT_ALLOCATOR_TOP_DEFINES_SVH
`define MAX_GAP_SEAT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MSA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MSA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/msa_pkg.sv =====
// Types and constants of the max-gap seat allocator.
`default_nettype none
package msa_pkg;

   localparam int unsigned POS_W    = 10;
   localparam int unsigned SC_W     = 11;
   localparam int unsigned TDATA_W  = 16;
   localparam logic [SC_W-1:0] SC_RESET = 11'd1024;

   localparam logic MODE_SEAT  = 1'b0;
   localparam logic MODE_LEAVE = 1'b1;

   typedef enum logic [1:0] {
      ST_SEATED = 2'd0,
      ST_LEFT   = 2'd1,
      ST_FULL   = 2'd2,
      ST_BAD    = 2'd3
   } status_type;

   // controls from the sequencer to the cell row
   typedef struct packed {
      logic shift;       // rotate the row by one seat
      logic clear_head;  // drop the head seat's bit as it wraps round
      logic set;         // occupy the seat on set_idx
   } ring_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/max_gap_seat_allocator_top.sv =====
// Top level of the max-gap seat allocator: stream ports, sequencer and cell row.
//
// Seat allocator over a row of MAX_SEATS seats. A seat beat (tuser = 0) takes
// the free seat furthest from any occupied one: seat 0, the lower midpoint of
// the widest inner gap, or the last seat, ties to the lowest index; an empty
// room gives seat 0, a full room gives status 2. A leave beat (tuser = 1)
// frees the seat in tdata, or reports status 3 if it is out of range or free.
// Occupancy lives in a ring of one-bit cells that rotates past a single scan
// unit; each request passes through the accept state, one full turn with a scan
// step for each seat, and a finish step that settles the result and waits
// while the output register is full. The ring length, not seat_count, sets
// the length of the turn. One item is in flight at a time; a finished
// result sits in an output register, so the next request is taken while it
// waits for rsp_tready. seat_count is written on the csr channel, which is
// always ready; write it only with the block idle.
`default_nettype none
`include "max_gap_seat_allocator_top_defines.svh"
module max_gap_seat_allocator_top import msa_pkg::*; #(
   parameter int unsigned MAX_SEATS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // requests
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [TDATA_W-1:0] req_tdata,   // [9:0] position, rest zero
   input  wire logic               req_tuser,   // [0] mode
   // results
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata,   // [9:0] seat_index, rest zero
   output logic [1:0]              rsp_tuser,   // [1:0] status
   // seat_count register
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [SC_W-1:0]    csr_wdata    // [10:0] seat_count
);

   localparam int unsigned IW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   // wide enough for any seat index, seat_count and MAX_SEATS itself
   localparam int unsigned CW = ((IW > SC_W) ? IW : SC_W) + 1;
   localparam logic [CW-1:0] MAX_W  = CW'(MAX_SEATS);
   localparam logic [IW-1:0] LAST_I = IW'(MAX_SEATS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type      state_ff, state_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic           any_ff, any_in;
   logic           hit_ff, hit_in;
   logic [CW-1:0]  prev_ff, prev_in;
   logic [CW-1:0]  best_dist_ff, best_dist_in;
   logic [CW-1:0]  best_seat_ff, best_seat_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [SC_W-1:0] sc_ff, sc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_seat_ff, rsp_seat_in;
   status_type     rsp_status_ff, rsp_status_in;

   ring_ctl_type   ctl;
   logic [IW-1:0]  set_idx;
   logic           head_occ;

   logic [CW-1:0]  n_eff;
   logic [CW-1:0]  i_w;
   logic [CW-1:0]  pos_w;
   logic [CW-1:0]  half;
   logic [CW-1:0]  right;
   logic [CW-1:0]  target;
   logic           in_range;
   logic           pos_ok;

   // effective seat count: zero acts as one, clipped to the ring length
   always_comb begin
      n_eff = CW'(sc_ff);
      if (sc_ff == '0) begin
         n_eff = CW'(1);
      end else if (CW'(sc_ff) > MAX_W) begin
         n_eff = MAX_W;
      end
   end

   assign i_w      = CW'(idx_ff);
   assign pos_w    = CW'(pos_ff);
   assign in_range = (i_w < n_eff);
   assign pos_ok   = (pos_w < n_eff);
   assign half     = (i_w - prev_ff) >> 1;
   assign right    = n_eff - CW'(1) - prev_ff;
   assign target   = any_ff ? ((right > best_dist_ff) ? (n_eff - CW'(1)) : best_seat_ff)
                            : '0;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      any_in        = any_ff;
      hit_in        = hit_ff;
      prev_in       = prev_ff;
      best_dist_in  = best_dist_ff;
      best_seat_in  = best_seat_ff;
      count_in      = count_ff;
      sc_in         = sc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_seat_in   = rsp_seat_ff;
      rsp_status_in = rsp_status_ff;
      ctl           = '0;
      set_idx       = target[IW-1:0];

      if (csr_valid && csr_ready) begin
         sc_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in      = req_tuser;
               pos_in       = req_tdata[POS_W-1:0];
               any_in       = 1'b0;
               hit_in       = 1'b0;
               prev_in      = '0;
               best_dist_in = '0;
               best_seat_in = '0;
               count_in     = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.shift = 1'b1;
            // one seat per cycle passes the head
            if (in_range && head_occ) begin
               count_in = count_ff + CW'(1);
               if (!any_ff) begin
                  best_dist_in = i_w;
                  best_seat_in = '0;
                  any_in       = 1'b1;
               end else if (half > best_dist_ff) begin
                  best_dist_in = half;
                  best_seat_in = prev_ff + half;
               end
               prev_in = i_w;
            end
            if ((mode_ff == MODE_LEAVE) && (i_w == pos_w)) begin
               hit_in         = head_occ;
               ctl.clear_head = pos_ok;
            end
            if (idx_ff == LAST_I) begin
               idx_in   = '0;
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_FINISH: begin
            // row is back at home; wait for room in the output register
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (mode_ff == MODE_LEAVE) begin
                  rsp_seat_in   = pos_ff;
                  rsp_status_in = (pos_ok && hit_ff) ? ST_LEFT : ST_BAD;
               end else if (count_ff == n_eff) begin
                  rsp_seat_in   = '0;
                  rsp_status_in = ST_FULL;
               end else begin
                  ctl.set       = 1'b1;
                  rsp_seat_in   = target[POS_W-1:0];
                  rsp_status_in = ST_SEATED;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         sc_ff        <= SC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sc_ff        <= sc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      any_ff        <= any_in;
      hit_ff        <= hit_in;
      prev_ff       <= prev_in;
      best_dist_ff  <= best_dist_in;
      best_seat_ff  <= best_seat_in;
      count_ff      <= count_in;
      rsp_seat_ff   <= rsp_seat_in;
      rsp_status_ff <= rsp_status_in;
   end

   msa_ring #(
      .MAX_SEATS (MAX_SEATS),
      .IW        (IW)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .set_idx  (set_idx),
      .head_occ (head_occ)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_seat_ff);
   assign rsp_tuser  = rsp_status_ff;

   // ring must sit at home whenever no scan runs
   `MSA_ASSERT_IMP(a_ring_home, clock, reset, state_ff != S_SCAN, idx_ff == '0, "ring not at home outside scan")
   // an accepted beat always starts a scan
   `MSA_ASSERT_NXT(a_accept_scan, clock, reset, req_tvalid && req_tready, state_ff == S_SCAN, "accepted beat did not start scan")
   // occupied count within range never passes n
   `MSA_ASSERT_IMP(a_count_le_n, clock, reset, state_ff == S_FINISH, count_ff <= n_eff, "occupied count above seat count")
   // a granted seat lies inside the room
   `MSA_ASSERT_IMP(a_grant_range, clock, reset, $rose(rsp_valid_ff) && (rsp_status_ff == ST_SEATED), CW'(rsp_seat_ff) < n_eff, "granted seat beyond seat count")

endmodule
`default_nettype wire

// ===== rtl/msa_cell.sv =====
// One seat cell: a single occupancy bit on the rotating row.
`default_nettype none
module msa_cell #(
   parameter int unsigned IW    = 10,
   parameter int unsigned INDEX = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          shift_en,
   input  wire logic          shift_in,
   input  wire logic          set_en,
   input  wire logic [IW-1:0] set_idx,
   output logic               occ
);

   logic occ_ff;
   logic occ_in;

   always_comb begin
      occ_in = occ_ff;
      if (shift_en) begin
         occ_in = shift_in;
      end
      // set only happens with the row at home, so the fixed index is the seat
      if (set_en && (set_idx == IW'(INDEX))) begin
         occ_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign occ = occ_ff;

endmodule
`default_nettype wire

// ===== rtl/msa_ring.sv =====
// Row of seat cells wired as a rotating ring, head at cell 0.
`default_nettype none
module msa_ring import msa_pkg::*; #(
   parameter int unsigned MAX_SEATS = 1024,
   parameter int unsigned IW        = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ring_ctl_type  ctl,
   input  wire logic [IW-1:0] set_idx,
   output logic               head_occ
);

   logic [MAX_SEATS-1:0] occ;
   logic [MAX_SEATS-1:0] link;

   // each cell takes its upper neighbour; the head wraps to the top cell
   always_comb begin
      link = {occ[0] & ~ctl.clear_head, occ[MAX_SEATS-1:1]};
   end

   for (genvar k = 0; k < MAX_SEATS; k++) begin : g_cell
      msa_cell #(
         .IW    (IW),
         .INDEX (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (ctl.shift),
         .shift_in (link[k]),
         .set_en   (ctl.set),
         .set_idx  (set_idx),
         .occ      (occ[k])
      );
   end

   assign head_occ = occ[0];

endmodule
`default_nettype wire
